// ===== hw/rtl/utf8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types, byte-class constants and the lead-byte classifier for the
// streaming UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POINT_W = 21;
  localparam int unsigned OWED_W  = 2;

  // Lead byte boundaries and payload masks
  localparam logic [BYTE_W-1:0] LEAD_ONE_LIM   = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD_TWO_LO    = 8'hC0;  // exclusive
  localparam logic [BYTE_W-1:0] LEAD_THREE_LO  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_FOUR_LO   = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_FOUR_LIM  = 8'hF8;
  localparam logic [BYTE_W-1:0] MASK_TWO       = 8'h1F;
  localparam logic [BYTE_W-1:0] MASK_THREE     = 8'h0F;
  localparam logic [BYTE_W-1:0] MASK_FOUR      = 8'h07;
  localparam logic [BYTE_W-1:0] MASK_CONT      = 8'h3F;
  localparam logic [BYTE_W-1:0] CONT_TAG_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG       = 8'h80;

  typedef enum logic [2:0] {
    LEAD_ONE,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_kind_t;

  typedef struct packed {
    logic [POINT_W-1:0] code_point;
    logic               bad_sequence;
    logic               out_last;
  } result_t;

  typedef struct packed {
    logic [POINT_W-1:0] partial_point;
    logic [OWED_W-1:0]  bytes_owed;
    logic               dropping_rest;
  } dec_state_t;

  function automatic lead_kind_t classify_lead(input logic [BYTE_W-1:0] b);
    lead_kind_t kind;
    if (b < LEAD_ONE_LIM) begin
      kind = LEAD_ONE;
    end else if (b > LEAD_TWO_LO && b < LEAD_THREE_LO) begin
      kind = LEAD_TWO;
    end else if (b >= LEAD_THREE_LO && b < LEAD_FOUR_LO) begin
      kind = LEAD_THREE;
    end else if (b >= LEAD_FOUR_LO && b < LEAD_FOUR_LIM) begin
      kind = LEAD_FOUR;
    end else begin
      kind = LEAD_BAD;
    end
    return kind;
  endfunction

endpackage

// ===== hw/rtl/utf8sd_byte_if.sv =====
// ----------------------------------------------------------------------------
// utf8sd_byte_if
// Valid/ready channel carrying one string byte and its end-of-string flag.
// ----------------------------------------------------------------------------
interface utf8sd_byte_if import utf8sd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== hw/rtl/utf8sd_point_if.sv =====
// ----------------------------------------------------------------------------
// utf8sd_point_if
// Valid/ready channel carrying one decoded code point or an error mark.
// ----------------------------------------------------------------------------
interface utf8sd_point_if import utf8sd_pkg::*;;
  logic               valid;
  logic               ready;
  logic [POINT_W-1:0] code_point;
  logic               bad_sequence;
  logic               out_last;

  modport source (output valid, output code_point, output bad_sequence,
                  output out_last, input ready);
  modport sink   (input valid, input code_point, input bad_sequence,
                  input out_last, output ready);
endinterface

// ===== hw/rtl/utf8sd_decode.sv =====
// ----------------------------------------------------------------------------
// utf8sd_decode
// Decoder state registers and the per-byte step: lead classification,
// continuation gathering, truncation and drop-to-end-of-string handling.
// ----------------------------------------------------------------------------
module utf8sd_decode import utf8sd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_last,
  output logic              res_valid,
  output result_t           result
);

  dec_state_t state;
  dec_state_t state_next;

  lead_kind_t         kind;
  logic [POINT_W-1:0] gathered;
  logic [OWED_W-1:0]  owed_dec;
  logic               err;

  always_comb begin
    kind       = classify_lead(in_byte);
    gathered   = {state.partial_point[POINT_W-7:0], in_byte[5:0]};
    owed_dec   = state.bytes_owed - OWED_W'(1);
    state_next = state;
    res_valid  = 1'b0;
    err        = 1'b0;
    result     = '0;

    if (state.dropping_rest) begin
      if (in_last) begin
        state_next = '0;
      end
    end else if (state.bytes_owed == '0) begin
      unique case (kind)
        LEAD_ONE: begin
          res_valid         = 1'b1;
          result.code_point = POINT_W'(in_byte);
          result.out_last   = in_last;
        end
        LEAD_TWO: begin
          state_next.partial_point = POINT_W'(in_byte & MASK_TWO);
          state_next.bytes_owed    = OWED_W'(1);
          err                      = in_last;
        end
        LEAD_THREE: begin
          state_next.partial_point = POINT_W'(in_byte & MASK_THREE);
          state_next.bytes_owed    = OWED_W'(2);
          err                      = in_last;
        end
        LEAD_FOUR: begin
          state_next.partial_point = POINT_W'(in_byte & MASK_FOUR);
          state_next.bytes_owed    = OWED_W'(3);
          err                      = in_last;
        end
        default: err = 1'b1;
      endcase
    end else if ((in_byte & CONT_TAG_MASK) != CONT_TAG) begin
      err = 1'b1;
    end else if (owed_dec == '0) begin
      res_valid                = 1'b1;
      result.code_point        = gathered;
      result.out_last          = in_last;
      state_next.partial_point = '0;
      state_next.bytes_owed    = '0;
    end else begin
      state_next.partial_point = gathered;
      state_next.bytes_owed    = owed_dec;
      err                      = in_last;
    end

    // any error: one bad result, clear the sequence, drop to string end
    if (err) begin
      res_valid                = 1'b1;
      result.code_point        = '0;
      result.bad_sequence      = 1'b1;
      result.out_last          = 1'b1;
      state_next.partial_point = '0;
      state_next.bytes_owed    = '0;
      state_next.dropping_rest = ~in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step) begin
      state <= state_next;
    end
  end

  a_err_starts_drop: assert property (@(posedge clk) disable iff (rst)
    step && res_valid && result.bad_sequence && !in_last |=> state.dropping_rest)
    else $error("error before string end did not start dropping");

  a_drop_no_seq: assert property (@(posedge clk) disable iff (rst)
    state.dropping_rest |-> state.bytes_owed == '0 && state.partial_point == '0)
    else $error("sequence state live while dropping");

  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    state.dropping_rest |-> !res_valid)
    else $error("result produced while dropping");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    step && in_last |=> state.bytes_owed == '0 && !state.dropping_rest)
    else $error("state not cleared at string end");

endmodule

// ===== hw/rtl/utf8_stream_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Streaming UTF-8 decoder: one byte in, at most one code point out.
// ----------------------------------------------------------------------------
// Usage:
//   bytes  : string bytes, in_last flags the final byte of each string.
//   points : one transaction per completed code point, or one error mark
//            (bad_sequence=1, code_point=0, out_last=1) on a bad byte or a
//            string that ends mid-sequence; the rest of that string is then
//            swallowed up to and including its last byte.
//   Bytes that only extend a sequence produce no transaction.
// Timing:
//   A byte passes through the byte register, then is decoded into the
//   result register. Throughput is one byte per cycle while points.ready
//   keeps the result register free; the decode step is a short
//   shift-and-or on a 21-bit register.
// Reset (rst, synchronous): drops any queued byte and result and clears the
//   partial code point, owed count and drop flag.
// Stall: while points.ready is low a held result stays put and the byte
//   register keeps one more byte; bytes.ready falls once both are full.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit import utf8sd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  utf8sd_byte_if.sink   bytes,
  utf8sd_point_if.source points
);

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_last;

  logic    o_valid;
  result_t o_result;

  logic    o_free;
  logic    step;
  logic    res_valid;
  result_t result;

  assign o_free      = ~o_valid | points.ready;
  assign step        = s1_valid & o_free;
  assign bytes.ready = ~s1_valid | o_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      s1_byte <= bytes.in_byte;
      s1_last <= bytes.in_last;
    end
  end

  utf8sd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .in_byte   (s1_byte),
    .in_last   (s1_last),
    .res_valid (res_valid),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_free) begin
      o_valid <= step & res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      o_result <= result;
    end
  end

  assign points.valid        = o_valid;
  assign points.code_point   = o_result.code_point;
  assign points.bad_sequence = o_result.bad_sequence;
  assign points.out_last     = o_result.out_last;

  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_result.bad_sequence |-> o_result.out_last && o_result.code_point == '0)
    else $error("error result not final or carries a code point");

  a_no_step_on_full: assert property (@(posedge clk) disable iff (rst)
    o_valid && !points.ready |-> !step)
    else $error("decode stepped while result register blocked");

  a_byte_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !step |=> s1_valid && $stable(s1_byte) && $stable(s1_last))
    else $error("unprocessed byte lost from input register");

endmodule

// ===== tb/sv/utf8sd_checker.sv =====
// ----------------------------------------------------------------------------
// utf8sd_checker
// Watches the byte and point channels of the UTF-8 decoder, predicts the
// code point or error mark that each accepted byte produces, and compares
// every accepted point transaction field by field against the oldest one due.
// ----------------------------------------------------------------------------
module utf8sd_checker import utf8sd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  utf8sd_byte_if  bytes_mon,
  utf8sd_point_if points_mon,
  output int     fail_count,
  output int     pending,
  output int     point_count,
  output int     bad_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Decoder state as seen by the predictor
  logic [POINT_W-1:0] cp_acc;
  logic [OWED_W-1:0]  owed_cnt;
  logic               dropping;

  result_t due_points[$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    point_count = 0;
    bad_count   = 0;
    cp_acc      = '0;
    owed_cnt    = '0;
    dropping    = 1'b0;
  end

  function automatic result_t mark_bad(input logic last);
    result_t r;
    r.code_point   = '0;
    r.bad_sequence = 1'b1;
    r.out_last     = 1'b1;
    cp_acc   = '0;
    owed_cnt = '0;
    dropping = !last;
    return r;
  endfunction

  // Returns 1 when the byte completes a code point or raises an error mark.
  function automatic bit decode_step(input logic [BYTE_W-1:0] b, input logic last,
                                     output result_t res);
    lead_kind_t kind;
    res = '0;
    if (dropping) begin
      if (last) begin
        dropping = 1'b0;
        cp_acc   = '0;
        owed_cnt = '0;
      end
      return 1'b0;
    end
    if (owed_cnt == 0) begin
      casez (b)
        8'b0???????: kind = LEAD_ONE;
        8'b110?????: kind = (b == LEAD_TWO_LO) ? LEAD_BAD : LEAD_TWO;
        8'b1110????: kind = LEAD_THREE;
        8'b11110???: kind = LEAD_FOUR;
        default:     kind = LEAD_BAD;
      endcase
      case (kind)
        LEAD_ONE: begin
          res.code_point = POINT_W'(b);
          res.out_last   = last;
          return 1'b1;
        end
        LEAD_TWO: begin
          cp_acc   = POINT_W'(b & MASK_TWO);
          owed_cnt = 2'd1;
        end
        LEAD_THREE: begin
          cp_acc   = POINT_W'(b & MASK_THREE);
          owed_cnt = 2'd2;
        end
        LEAD_FOUR: begin
          cp_acc   = POINT_W'(b & MASK_FOUR);
          owed_cnt = 2'd3;
        end
        default: begin
          res = mark_bad(last);
          return 1'b1;
        end
      endcase
      // multi-byte lead on the last byte is a truncation
      if (last) begin
        res = mark_bad(1'b1);
        return 1'b1;
      end
      return 1'b0;
    end
    if ((b & CONT_TAG_MASK) != CONT_TAG) begin
      res = mark_bad(last);
      return 1'b1;
    end
    cp_acc   = {cp_acc[POINT_W-7:0], b[5:0]};
    owed_cnt = owed_cnt - 2'd1;
    if (owed_cnt == 0) begin
      res.code_point = cp_acc;
      res.out_last   = last;
      cp_acc         = '0;
      return 1'b1;
    end
    if (last) begin
      res = mark_bad(1'b1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    if (rst) begin
      cp_acc   = '0;
      owed_cnt = '0;
      dropping = 1'b0;
      due_points.delete();
    end else begin
      if (bytes_mon.valid && bytes_mon.ready) begin
        if (decode_step(bytes_mon.in_byte, bytes_mon.in_last, want))
          due_points.insert(due_points.size(), want);
      end
      if (points_mon.valid && points_mon.ready) begin
        got.code_point   = points_mon.code_point;
        got.bad_sequence = points_mon.bad_sequence;
        got.out_last     = points_mon.out_last;
        if (due_points.size() == 0) begin
          $error("unexpected point transaction: code_point %h bad_sequence %b out_last %b",
                 got.code_point, got.bad_sequence, got.out_last);
          fail_count++;
        end else begin
          want = due_points.pop_front();
          if (got.code_point !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point, got.code_point);
            fail_count++;
          end
          if (got.bad_sequence !== want.bad_sequence) begin
            $error("bad_sequence: expected %b, got %b", want.bad_sequence, got.bad_sequence);
            fail_count++;
          end
          if (got.out_last !== want.out_last) begin
            $error("out_last: expected %b, got %b", want.out_last, got.out_last);
            fail_count++;
          end
          if (want.bad_sequence) bad_count++;
          else point_count++;
        end
      end
    end
    pending = due_points.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives byte strings into utf8_stream_decoder_unit: a directed set of lead
// and continuation corner cases, then random strings that are mostly valid
// UTF-8 with truncations, stray bytes and bad continuations mixed in. Both
// channels idle at random; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench import utf8sd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BYTE_TARGET = 725;

  // {in_last, in_byte}
  localparam logic [8:0] DIRECT_SEQ [0:24] = '{
    9'h000, 9'h17F,                  // ascii extremes
    9'h0C1, 9'h180,                  // lowest two-byte lead, ends on last byte
    9'h0DF, 9'h0BF,                  // 0x7FF
    9'h0E0, 9'h080, 9'h180,          // three-byte ending at string end
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,  // 0x1FFFFF
    9'h080, 9'h041, 9'h1FF,          // stray continuation as lead, rest dropped
    9'h1C0,                          // 0xC0 lead on last byte
    9'h0F8, 9'h100,                  // 0xF8 lead, drop through last
    9'h0E5, 9'h041, 9'h17F,          // bad continuation
    9'h1F0,                          // four-byte lead on last byte
    9'h0EF, 9'h1BF                   // string ends one byte short
  };

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  int   n_points;
  int   n_bad;
  int   sent;
  int   n_strings;

  utf8sd_byte_if  byte_ch ();
  utf8sd_point_if point_ch ();

  utf8_stream_decoder_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_ch),
    .points (point_ch)
  );

  utf8sd_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .bytes_mon   (byte_ch),
    .points_mon  (point_ch),
    .fail_count  (fails),
    .pending     (pending),
    .point_count (n_points),
    .bad_count   (n_bad)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("** utf8_stream_decoder_unit: FAILED **");
    $finish;
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [BYTE_W-1:0] lead_byte(input int width);
    case (width)
      1:       return BYTE_W'($urandom_range(8'h00, 8'h7F));
      2:       return BYTE_W'($urandom_range(8'hC1, 8'hDF));
      3:       return BYTE_W'($urandom_range(8'hE0, 8'hEF));
      default: return BYTE_W'($urandom_range(8'hF0, 8'hF7));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] cont_byte();
    return CONT_TAG | BYTE_W'($urandom_range(0, 63));
  endfunction

  // Valid stays high between back-to-back transactions.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last, input bit steady);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    byte_ch.in_last <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    byte_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Result side: random bursts of ready, occasionally a long open stretch.
  initial begin
    int burst;
    int gap;
    point_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
      point_ch.ready <= 1'b1;
      repeat (burst) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        point_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    logic [BYTE_W-1:0] str[$];
    int  nchars;
    int  r;
    int  w;
    bit  steady;
    bit  paused;
    sent      = 0;
    n_strings = 0;
    paused    = 1'b0;
    rst             <= 1'b1;
    byte_ch.valid   <= 1'b0;
    byte_ch.in_byte <= '0;
    byte_ch.in_last <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECT_SEQ[i]) send_byte(DIRECT_SEQ[i][7:0], DIRECT_SEQ[i][8], 1'b0);
    n_strings += 9;
    drain();

    while (sent < BYTE_TARGET) begin
      str.delete();
      nchars = $urandom_range(1, 10);
      repeat (nchars) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          w = $urandom_range(1, 4);
          str.insert(str.size(), lead_byte(w));
          repeat (w - 1) str.insert(str.size(), cont_byte());
        end else if (r < 88) begin
          str.insert(str.size(), BYTE_W'($urandom_range(0, 255)));
        end else begin
          // sequence cut short; optionally followed by a non-continuation byte
          w = $urandom_range(2, 4);
          str.insert(str.size(), lead_byte(w));
          repeat ($urandom_range(0, w - 2)) str.insert(str.size(), cont_byte());
          if (r >= 94)
            str.insert(str.size(),
                       $urandom_range(0, 1) ? BYTE_W'($urandom_range(8'h00, 8'h7F))
                                            : BYTE_W'($urandom_range(8'hC0, 8'hFF)));
        end
      end
      steady = ($urandom_range(0, 4) == 0);
      foreach (str[i]) send_byte(str[i], i == str.size() - 1, steady);
      n_strings++;
      if (!paused && sent >= BYTE_TARGET / 2) begin
        paused = 1'b1;
        drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Run covered %0d bytes in %0d strings: %0d code points and %0d error marks checked.",
             sent, n_strings, n_points, n_bad);
    if (fails == 0 && pending == 0) begin
      $display("** utf8_stream_decoder_unit: PASSED **");
    end else begin
      $display("** utf8_stream_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
